FILE: hw/rtl/run_strip_triangle_index_builder_macros.svh
// Assertion helpers for the run strip triangle index builder.
`ifndef RUN_STRIP_TRIANGLE_INDEX_BUILDER_MACROS_SVH
`define RUN_STRIP_TRIANGLE_INDEX_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
`define RSTIB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rstib: same-cycle check failed");
`define RSTIB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rstib: next-cycle check failed");
`else
`define RSTIB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RSTIB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/rstib_pkg.sv
`default_nettype none
package rstib_pkg;

  localparam int unsigned MAX_VERTICES = 2048;
  localparam int unsigned POS_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned INDEX_W      = 16;
  localparam int unsigned CORNER_W     = 11;
  localparam int unsigned RUN_W        = 2;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(3);

  typedef enum logic {
    KIND_TRIANGLE = 1'b0,
    KIND_SUMMARY  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               end_of_list;
  } vertex_t;

  typedef struct packed {
    kind_e               kind;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] triangle_total;
    logic                overflow;
    logic                last;
  } result_t;

  // one queue entry: everything an item needs to produce its results
  typedef struct packed {
    logic                has_tri;
    logic                eol;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] total;
    logic                overflow;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rstib_front.sv
`default_nettype none
module rstib_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rstib_pkg::vertex_t vertex_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output rstib_pkg::cmd_t  q_cmd_o
);
  import rstib_pkg::*;

  logic [INDEX_W-1:0]  prev_q, prev_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [CORNER_W-1:0] tri_q, tri_d;
  logic                drop_q, drop_d;

  logic                accept;
  logic                at_cap;
  logic                cont;
  logic                emit_tri;
  logic [CORNER_W-1:0] p_c;
  logic [CORNER_W-1:0] p_m1;
  logic [CORNER_W-1:0] p_m2;

  assign accept = push_i && !q_full_i;
  assign at_cap = (pos_q >= POS_W'(MAX_VERTICES));
  assign cont   = (pos_q != '0) &&
                  (({1'b0, prev_q} + (INDEX_W+1)'(1)) == {1'b0, vertex_i.vertex_index});
  assign p_c    = CORNER_W'(pos_q);
  assign p_m1   = p_c - CORNER_W'(1);
  assign p_m2   = p_c - CORNER_W'(2);

  always_comb begin
    prev_d   = prev_q;
    pos_d    = pos_q;
    run_d    = run_q;
    tri_d    = tri_q;
    drop_d   = drop_q;
    emit_tri = 1'b0;
    if (accept) begin
      if (at_cap) begin
        drop_d = 1'b1;
      end else begin
        if (cont) begin
          if (run_q != RUN_FULL) begin
            run_d = run_q + RUN_W'(1);
          end
        end else begin
          run_d = RUN_W'(1);
        end
        if (run_d == RUN_FULL) begin
          emit_tri = 1'b1;
          if (tri_q != '1) begin
            tri_d = tri_q + CORNER_W'(1);
          end
        end
        prev_d = vertex_i.vertex_index;
        pos_d  = pos_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    q_push_o         = accept && (emit_tri || vertex_i.end_of_list);
    q_cmd_o.has_tri  = emit_tri;
    q_cmd_o.eol      = vertex_i.end_of_list;
    q_cmd_o.corner_a = p_m2;
    // winding flips when the index two back is odd
    q_cmd_o.corner_b = vertex_i.vertex_index[0] ? p_c : p_m1;
    q_cmd_o.corner_c = vertex_i.vertex_index[0] ? p_m1 : p_c;
    q_cmd_o.total    = tri_d;
    q_cmd_o.overflow = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= '0;
      run_q  <= '0;
      tri_q  <= '0;
      drop_q <= 1'b0;
    end else if (accept && vertex_i.end_of_list) begin
      prev_q <= '0;
      pos_q  <= '0;
      run_q  <= '0;
      tri_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pos_q  <= pos_d;
      run_q  <= run_d;
      tri_q  <= tri_d;
      drop_q <= drop_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rstib_queue.sv
`default_nettype none
module rstib_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rstib_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rstib_pkg::cmd_t cmd_o
);
  import rstib_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d;
  logic [QUEUE_AW-1:0] rd_q, rd_d;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? QUEUE_AW'(wr_q + QUEUE_AW'(1)) : wr_q;
    rd_d  = do_pop  ? QUEUE_AW'(rd_q + QUEUE_AW'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rstib_back.sv
`default_nettype none
`include "run_strip_triangle_index_builder_macros.svh"
module rstib_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  rstib_pkg::cmd_t    q_cmd_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output rstib_pkg::result_t result_o
);
  import rstib_pkg::*;

  result_t res_q, res_d;
  logic    valid_q, valid_d;
  logic    phase_q, phase_d;
  logic    pop_acc;
  logic    load;
  logic    tri_now;
  logic    cmd_done;

  assign pop_acc  = pop_i && valid_q;
  assign load     = !q_empty_i && (!valid_q || pop_acc);
  assign tri_now  = q_cmd_i.has_tri && !phase_q;
  assign cmd_done = tri_now ? !q_cmd_i.eol : 1'b1;
  assign q_pop_o  = load && cmd_done;
  assign empty_o  = !valid_q;
  assign result_o = res_q;

  always_comb begin
    res_d.triangle_total = q_cmd_i.total;
    res_d.overflow       = q_cmd_i.overflow;
    if (tri_now) begin
      res_d.kind     = KIND_TRIANGLE;
      res_d.corner_a = q_cmd_i.corner_a;
      res_d.corner_b = q_cmd_i.corner_b;
      res_d.corner_c = q_cmd_i.corner_c;
      res_d.last     = 1'b0;
    end else begin
      res_d.kind     = KIND_SUMMARY;
      res_d.corner_a = '0;
      res_d.corner_b = '0;
      res_d.corner_c = '0;
      res_d.last     = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = !cmd_done;
    end else if (pop_acc) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  `RSTIB_ASSERT_IMP(a_summary_is_last, clk_i, rst_ni,
    valid_q, ((res_q.kind == KIND_SUMMARY) == res_q.last))
  `RSTIB_ASSERT_IMP(a_summary_no_corners, clk_i, rst_ni,
    valid_q && res_q.last, (res_q.corner_a == '0) && (res_q.corner_b == '0))
  `RSTIB_ASSERT_NXT(a_tri_then_summary, clk_i, rst_ni,
    load && tri_now && q_cmd_i.eol, phase_q && !q_empty_i)
  `RSTIB_ASSERT_IMP(a_phase_needs_eol, clk_i, rst_ni,
    phase_q, !q_empty_i && q_cmd_i.eol && q_cmd_i.has_tri)

endmodule
`default_nettype wire

FILE: hw/rtl/run_strip_triangle_index_builder.sv
`default_nettype none
// Run strip triangle index builder. Push sorted vertex indices in, one per
// cycle while full_o is low; each vertex that is the third or later of a run
// of consecutive indices yields a triangle over sorted positions, and the
// vertex marked end_of_list also yields a summary with the triangle count and
// the overflow flag, after which the list state starts over. The front stage
// classifies a vertex in its accept cycle, a four-entry queue carries the
// work, and the back stage writes one result per cycle into the output
// register while that register is free or being popped, so a result passes
// through a queue entry and then the output register on its way out.
// Input is taken in every cycle that full_o is low; output drains at one
// result per cycle while pop_i is high. A vertex that ends a list with a
// triangle yields two results, and the queue absorbs that until pop keeps pace.
module run_strip_triangle_index_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  rstib_pkg::vertex_t vertex_i,
  output logic               empty_o,
  input  logic               pop_i,
  output rstib_pkg::result_t result_o
);
  import rstib_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign full_o = q_full;

  rstib_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .vertex_i (vertex_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (cmd_in)
  );

  rstib_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_out)
  );

  rstib_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (cmd_out),
    .q_pop_o   (q_pop),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .result_o  (result_o)
  );

endmodule
`default_nettype wire

FILE: sim/run_strip_checker.sv
`default_nettype none
module run_strip_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_o,
  input  rstib_pkg::vertex_t vertex_i,
  input  logic               empty_o,
  input  logic               pop_i,
  input  rstib_pkg::result_t result_o,
  output int                 pending_o,
  output int                 fail_count_o
);
  import rstib_pkg::*;

  logic [INDEX_W-1:0]  last_index;
  logic [11:0]         accepted_count;
  logic [RUN_W-1:0]    run_len;
  logic [CORNER_W-1:0] tri_count;
  logic                dropped;
  result_t             triangle_q[$];
  int                  fails;

  initial begin
    fails = 0;
  end

  task automatic report_failure(input string what, input int got, input int want);
    fails++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic clear_list_state();
    last_index     = '0;
    accepted_count = '0;
    run_len        = '0;
    tri_count      = '0;
    dropped        = 1'b0;
  endtask

  function automatic result_t make_result(input kind_e k, input logic [CORNER_W-1:0] a,
                                          input logic [CORNER_W-1:0] b,
                                          input logic [CORNER_W-1:0] c, input logic last);
    result_t r;
    r.kind           = k;
    r.corner_a       = a;
    r.corner_b       = b;
    r.corner_c       = c;
    r.triangle_total = tri_count;
    r.overflow       = dropped;
    r.last           = last;
    return r;
  endfunction

  task automatic predict_vertex(input vertex_t v);
    logic [CORNER_W-1:0] p;
    logic                chained;
    if (accepted_count >= 12'(MAX_VERTICES)) begin
      dropped = 1'b1;
    end else begin
      p       = accepted_count[CORNER_W-1:0];
      chained = (accepted_count != '0) &&
                ({1'b0, last_index} + 17'd1 == {1'b0, v.vertex_index});
      if (!chained) begin
        run_len = RUN_W'(1);
      end else if (run_len != RUN_FULL) begin
        run_len = run_len + RUN_W'(1);
      end
      if (run_len == RUN_FULL) begin
        if (tri_count != '1) begin
          tri_count = tri_count + CORNER_W'(1);
        end
        // odd index two back swaps the winding
        if (v.vertex_index[0]) begin
          triangle_q.push_back(make_result(KIND_TRIANGLE, p - CORNER_W'(2), p,
                                           p - CORNER_W'(1), 1'b0));
        end else begin
          triangle_q.push_back(make_result(KIND_TRIANGLE, p - CORNER_W'(2),
                                           p - CORNER_W'(1), p, 1'b0));
        end
      end
      last_index     = v.vertex_index;
      accepted_count = accepted_count + 12'd1;
    end
    if (v.end_of_list) begin
      triangle_q.push_back(make_result(KIND_SUMMARY, '0, '0, '0, 1'b1));
      clear_list_state();
    end
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind !== want.kind)
      report_failure("kind", got.kind, want.kind);
    if (got.corner_a !== want.corner_a)
      report_failure("corner_a", got.corner_a, want.corner_a);
    if (got.corner_b !== want.corner_b)
      report_failure("corner_b", got.corner_b, want.corner_b);
    if (got.corner_c !== want.corner_c)
      report_failure("corner_c", got.corner_c, want.corner_c);
    if (got.triangle_total !== want.triangle_total)
      report_failure("triangle_total", got.triangle_total, want.triangle_total);
    if (got.overflow !== want.overflow)
      report_failure("overflow", got.overflow, want.overflow);
    if (got.last !== want.last)
      report_failure("last", got.last, want.last);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_list_state();
      triangle_q.delete();
    end else begin
      if (push_i && !full_o) begin
        predict_vertex(vertex_i);
      end
      if (pop_i && !empty_o) begin
        if (triangle_q.size() == 0) begin
          report_failure("result with none expected, kind", result_o.kind, -1);
        end else begin
          check_result(result_o, triangle_q.pop_front());
        end
      end
    end
    pending_o    <= triangle_q.size();
    fail_count_o <= fails;
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
  import rstib_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_DIRECTED = 18;

  typedef enum int {
    POP_ALWAYS,
    POP_COIN,
    POP_PATTERN
  } pop_mode_e;

  logic    clk_i    = 1'b0;
  logic    rst_ni   = 1'b0;
  logic    push_i   = 1'b0;
  logic    pop_i    = 1'b0;
  vertex_t vertex_i = '0;
  logic    full_o;
  logic    empty_o;
  result_t result_o;
  int      pending;
  int      fail_count;

  int        burst_left    = 0;
  int        hold_requests = 0;
  int        holds_served  = 0;
  int        hold_left     = 0;
  int        mode_left     = 0;
  int        idle_cycles   = 0;
  pop_mode_e pop_mode      = POP_ALWAYS;
  logic [31:0] stall_pattern = '1;

  int unsigned dir_index [NUM_DIRECTED] = '{0, 1, 2, 3, 65535, 1, 2, 3, 3, 4, 5, 4,
                                            65533, 65534, 65535, 0, 1, 2};
  bit          dir_eol   [NUM_DIRECTED] = '{0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0,
                                            0, 0, 0, 0, 0, 1};

  always #10 clk_i = ~clk_i;

  run_strip_triangle_index_builder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .vertex_i (vertex_i),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .result_o (result_o)
  );

  run_strip_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .vertex_i     (vertex_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .result_o     (result_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  task automatic push_vertex(input logic [INDEX_W-1:0] idx, input logic eol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    push_i   <= 1'b1;
    vertex_i <= '{vertex_index: idx, end_of_list: eol};
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_list(input int len, input int break_pct);
    logic [INDEX_W-1:0] idx;
    int                 r;
    idx = INDEX_W'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        r = $urandom_range(0, 99);
        if (r >= break_pct) begin
          idx = idx + 16'd1;
        end else if (r < break_pct / 3) begin
          idx = idx + INDEX_W'($urandom_range(2, 50));
        end else if (r < break_pct / 2) begin
          idx = idx;
        end else if (r < (break_pct * 3) / 4) begin
          idx = idx - INDEX_W'($urandom_range(1, 5));
        end else begin
          idx = INDEX_W'($urandom);
        end
      end
      push_vertex(idx, i == len - 1);
    end
  endtask

  task automatic random_lists(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(3, 60);
      send_list(len, $urandom_range(5, 40));
      sent += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      push_vertex(INDEX_W'(dir_index[i]), dir_eol[i]);
    end
    wait_drained();

    hold_requests++;
    random_lists(100);
    wait_drained();

    // fills to capacity, then drops, the end marker on a dropped vertex
    hold_requests++;
    send_list(MAX_VERTICES + 2, 2);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      pop_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode      = pop_mode_e'($urandom_range(0, 2));
        stall_pattern = $urandom;
        mode_left     = $urandom_range(16, 200);
      end
      mode_left--;
      case (pop_mode)
        POP_ALWAYS: begin
          pop_i <= 1'b1;
        end
        POP_COIN: begin
          pop_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          pop_i <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
`default_nettype wire
